// ===== design/tosp_pkg.sv =====
// Package for the tree object stream parser.
// Holds the byte-kind codes, the parser phase type, character constants and the result struct.
// No dependencies.
package tosp_pkg;

   // Classification reported for every byte
   typedef enum logic [2:0] {
      KIND_IGNORED = 3'd0,
      KIND_MODE    = 3'd1,
      KIND_NAME    = 3'd2,
      KIND_HASH    = 3'd3,
      KIND_TERM    = 3'd4
   } kind_type;

   // Field currently being parsed, one-hot
   typedef enum logic [2:0] {
      PHASE_MODE = 3'b001,
      PHASE_NAME = 3'b010,
      PHASE_HASH = 3'b100
   } phase_type;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;

   // One result transaction
   typedef struct packed {
      kind_type    byte_kind;
      logic [7:0]  echo_byte;
      logic [7:0]  field_pos;
      logic        entry_done;
      logic [7:0]  entry_index;
      logic [31:0] mode_value;
      logic [8:0]  entry_count;
      logic        finished;
      logic        failed;
   } rsp_type;

endpackage

// ===== design/tosp_if.sv =====
// Channel interfaces of the tree object stream parser: byte input and result output.
// Valid/ready handshake; a transaction moves when both are high at a rising edge.
// No dependencies.
interface tosp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_end;

   modport source (output valid, output data_byte, output is_end, input ready);
   modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

interface tosp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_kind;
   logic [7:0]  echo_byte;
   logic [7:0]  field_pos;
   logic        entry_done;
   logic [7:0]  entry_index;
   logic [31:0] mode_value;
   logic [8:0]  entry_count;
   logic        finished;
   logic        failed;

   modport source (output valid, output byte_kind, output echo_byte, output field_pos,
                   output entry_done, output entry_index, output mode_value,
                   output entry_count, output finished, output failed, input ready);
   modport sink   (input valid, input byte_kind, input echo_byte, input field_pos,
                   input entry_done, input entry_index, input mode_value,
                   input entry_count, input finished, input failed, output ready);
endinterface

// ===== design/tosp_core.sv =====
// Parser core: holds the parse state and computes one result per stepped byte.
// State updates on step_valid; the result is combinational from the current state and byte.
// Depends on tosp_pkg.
module tosp_core #(
   parameter int MAX_ENTRIES      = 256,
   parameter int HASH_BYTES       = 32,
   parameter int NAME_BYTES       = 256,
   parameter int MODE_FIELD_BYTES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_valid,
   input  logic [7:0]       data_byte,
   input  logic             is_end,
   output tosp_pkg::rsp_type result
);
   import tosp_pkg::*;

   localparam int MAX_FIELD = (NAME_BYTES > MODE_FIELD_BYTES)
                              ? ((NAME_BYTES > HASH_BYTES) ? NAME_BYTES : HASH_BYTES)
                              : ((MODE_FIELD_BYTES > HASH_BYTES) ? MODE_FIELD_BYTES
                                                                 : HASH_BYTES);
   localparam int POS_W = (MAX_FIELD > 2) ? $clog2(MAX_FIELD) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [POS_W-1:0] MODE_LAST = POS_W'(MODE_FIELD_BYTES - 1);
   localparam logic [POS_W-1:0] NAME_LAST = POS_W'(NAME_BYTES - 1);
   localparam logic [POS_W-1:0] HASH_LAST = POS_W'(HASH_BYTES - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ENTRIES);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      accum_ff, accum_in;
   logic             stopped_ff, stopped_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             err_ff, err_in;

   logic        live;
   logic        is_octal;
   logic [31:0] pos_wide;
   logic [31:0] cnt_wide;
   logic [31:0] cnt_next_wide;

   assign live          = !err_ff && (cnt_ff < CNT_LIMIT);
   assign is_octal      = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_SEVEN);
   assign pos_wide      = 32'(pos_ff);
   assign cnt_wide      = 32'(cnt_ff);
   assign cnt_next_wide = 32'(cnt_in);

   // Next state and result for the byte at hand
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      accum_in   = accum_ff;
      stopped_in = stopped_ff;
      cnt_in     = cnt_ff;
      err_in     = err_ff;

      result             = '0;
      result.byte_kind   = KIND_IGNORED;
      result.echo_byte   = data_byte;
      result.entry_index = cnt_wide[7:0];

      if (is_end) begin
         // end of buffer: report status, then clear everything
         result.echo_byte = '0;
         result.finished = 1'b1;
         result.failed   = err_ff || (live && (phase_ff != PHASE_MODE || pos_ff != '0));
         result.entry_count = cnt_wide[8:0];
         phase_in   = PHASE_MODE;
         pos_in     = '0;
         accum_in   = '0;
         stopped_in = 1'b0;
         cnt_in     = '0;
         err_in     = 1'b0;
      end else begin
         if (live) begin
            unique case (phase_ff)
               PHASE_MODE: begin
                  if (data_byte == CHAR_SPACE) begin
                     result.byte_kind = KIND_TERM;
                     result.field_pos = pos_wide[7:0];
                     phase_in = PHASE_NAME;
                     pos_in   = '0;
                  end else if (pos_ff >= MODE_LAST) begin
                     err_in = 1'b1;
                  end else begin
                     result.byte_kind = KIND_MODE;
                     result.field_pos = pos_wide[7:0];
                     if (!stopped_ff && is_octal) begin
                        accum_in = {accum_ff[28:0], data_byte[2:0]};
                     end else begin
                        stopped_in = 1'b1;
                     end
                     pos_in = pos_ff + 1'b1;
                  end
               end
               PHASE_NAME: begin
                  if (data_byte == CHAR_NUL) begin
                     result.byte_kind = KIND_TERM;
                     result.field_pos = pos_wide[7:0];
                     phase_in = PHASE_HASH;
                     pos_in   = '0;
                  end else if (pos_ff >= NAME_LAST) begin
                     err_in = 1'b1;
                  end else begin
                     result.byte_kind = KIND_NAME;
                     result.field_pos = pos_wide[7:0];
                     pos_in = pos_ff + 1'b1;
                  end
               end
               PHASE_HASH: begin
                  result.byte_kind = KIND_HASH;
                  result.field_pos = pos_wide[7:0];
                  if (pos_ff == HASH_LAST) begin
                     // last hash byte closes the entry
                     result.entry_done = 1'b1;
                     result.mode_value = accum_ff;
                     cnt_in     = cnt_ff + 1'b1;
                     phase_in   = PHASE_MODE;
                     pos_in     = '0;
                     accum_in   = '0;
                     stopped_in = 1'b0;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
               default: begin
                  err_in = err_ff;
               end
            endcase
         end
         result.entry_count = cnt_next_wide[8:0];
         result.failed      = err_in;
      end
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_MODE;
         pos_ff     <= '0;
         accum_ff   <= '0;
         stopped_ff <= 1'b0;
         cnt_ff     <= '0;
         err_ff     <= 1'b0;
      end else if (step_valid) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         accum_ff   <= accum_in;
         stopped_ff <= stopped_in;
         cnt_ff     <= cnt_in;
         err_ff     <= err_in;
      end
   end

   // Entry counter never passes the limit
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LIMIT)
      else $error("entry count beyond limit");

   // An end transaction leaves a cleared parser
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step_valid && is_end |=> cnt_ff == '0 && !err_ff && pos_ff == '0 && accum_ff == '0)
      else $error("state not cleared after end transaction");

   // Error flag and entry count only move on a step
   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      !step_valid |=> $stable(err_ff) && $stable(cnt_ff))
      else $error("state changed without a step");

   // A completed entry is always reported on a hash byte and bumps the count
   a_done_hash: assert property (@(posedge clock) disable iff (reset)
      step_valid && result.entry_done |-> result.byte_kind == KIND_HASH &&
                                          cnt_in == cnt_ff + 1'b1)
      else $error("entry completion outside hash field");

endmodule

// ===== design/tosp_rsp_reg.sv =====
// Result register of the tree object stream parser: holds one result until taken.
// Accepts a new result in the same cycle the held one leaves.
// Depends on tosp_pkg and tosp_rsp_if.
module tosp_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  tosp_pkg::rsp_type load_data,
   output logic              can_load,
   tosp_rsp_if.source        rsp_ch
);
   import tosp_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ch.ready;

   // Valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load_valid;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (can_load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.byte_kind   = data_ff.byte_kind;
   assign rsp_ch.echo_byte   = data_ff.echo_byte;
   assign rsp_ch.field_pos   = data_ff.field_pos;
   assign rsp_ch.entry_done  = data_ff.entry_done;
   assign rsp_ch.entry_index = data_ff.entry_index;
   assign rsp_ch.mode_value  = data_ff.mode_value;
   assign rsp_ch.entry_count = data_ff.entry_count;
   assign rsp_ch.finished    = data_ff.finished;
   assign rsp_ch.failed      = data_ff.failed;

endmodule

// ===== design/tree_object_stream_parser.sv =====
// Top level of the tree object stream parser: input register, parser core, result register.
// Depends on tosp_pkg, tosp_if, tosp_core and tosp_rsp_reg.
//
//   channel   direction  transaction
//   req_ch    in         one object byte, or the end marker
//   rsp_ch    out        one result per request: kind, position, entry status
//
// One request per cycle sustained while rsp_ch is ready; a request passes the input register, then the result register.
// The parser state updates in the cycle a byte moves from the input register
// into the result register, so a full result register stalls the input stage.
// Synchronous reset clears the handshake flags and the parse state.
module tree_object_stream_parser #(
   parameter int MAX_ENTRIES      = 256,
   parameter int HASH_BYTES       = 32,
   parameter int NAME_BYTES       = 256,
   parameter int MODE_FIELD_BYTES = 16
) (
   input logic        clock,
   input logic        reset,
   tosp_req_if.sink   req_ch,
   tosp_rsp_if.source rsp_ch
);
   import tosp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       can_load;
   logic       advance;
   rsp_type    step_result;

   assign advance      = in_valid_ff && can_load;
   assign req_ch.ready = !in_valid_ff || advance;

   // Input register valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.data_byte;
         in_end_ff  <= req_ch.is_end;
      end
   end

   tosp_core #(
      .MAX_ENTRIES      (MAX_ENTRIES),
      .HASH_BYTES       (HASH_BYTES),
      .NAME_BYTES       (NAME_BYTES),
      .MODE_FIELD_BYTES (MODE_FIELD_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .data_byte  (in_byte_ff),
      .is_end     (in_end_ff),
      .result     (step_result)
   );

   tosp_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (advance),
      .load_data  (step_result),
      .can_load   (can_load),
      .rsp_ch     (rsp_ch)
   );

endmodule
